FILE: src/spct_pkg.sv
// ----------------------------------------------------------------------------
// Shape pixel coverage test package
// Shared constants: coordinate width default, register indexes, shape codes.
// ----------------------------------------------------------------------------
package spct_pkg;

   localparam int COORD_BITS_DEF = 12;
   localparam int COLOR_BITS     = 24;
   localparam int CHANNEL_BITS   = 8;
   localparam int CSR_INDEX_BITS = 3;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_SHAPE_KIND = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_VERTEX_A   = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_VERTEX_B   = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_VERTEX_C   = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RADIUS     = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FILL_COLOR = 3'd5;

   localparam logic SHAPE_TRIANGLE = 1'b0;
   localparam logic SHAPE_CIRCLE   = 1'b1;

endpackage

FILE: src/spct_if.sv
// ----------------------------------------------------------------------------
// Shape pixel coverage test channels
// Valid/ready channels for pixel requests and coverage responses.
// ----------------------------------------------------------------------------
interface spct_req_if #(
   parameter int COORD_BITS = spct_pkg::COORD_BITS_DEF
);
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] pixel_x;
   logic [COORD_BITS-1:0] pixel_y;

   modport source (output valid, output pixel_x, output pixel_y, input ready);
   modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface spct_rsp_if #(
   parameter int COORD_BITS = spct_pkg::COORD_BITS_DEF
);
   logic                  valid;
   logic                  ready;
   logic                  write_pixel;
   logic [COORD_BITS-1:0] out_x;
   logic [COORD_BITS-1:0] out_y;
   logic [7:0]            red;
   logic [7:0]            green;
   logic [7:0]            blue;

   modport source (output valid, output write_pixel, output out_x, output out_y,
                   output red, output green, output blue, input ready);
   modport sink   (input valid, input write_pixel, input out_x, input out_y,
                   input red, input green, input blue, output ready);
endinterface

FILE: src/spct_cfg_regs.sv
// ----------------------------------------------------------------------------
// Shape pixel coverage test configuration registers
// Write-only register bank holding the shape, its vertices, the radius and the fill color.
// ----------------------------------------------------------------------------
module spct_cfg_regs #(
   parameter int COORD_BITS    = spct_pkg::COORD_BITS_DEF,
   parameter int CSR_DATA_BITS = spct_pkg::COLOR_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wen,
   input  logic [spct_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]            csr_wdata,
   output logic                                shape_kind,
   output logic [2*COORD_BITS-1:0]             vertex_a,
   output logic [2*COORD_BITS-1:0]             vertex_b,
   output logic [2*COORD_BITS-1:0]             vertex_c,
   output logic [COORD_BITS-1:0]               radius,
   output logic [spct_pkg::COLOR_BITS-1:0]     fill_color
);
   import spct_pkg::*;

   logic                    shape_kind_ff;
   logic [2*COORD_BITS-1:0] vertex_a_ff;
   logic [2*COORD_BITS-1:0] vertex_b_ff;
   logic [2*COORD_BITS-1:0] vertex_c_ff;
   logic [COORD_BITS-1:0]   radius_ff;
   logic [COLOR_BITS-1:0]   fill_color_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         shape_kind_ff <= 1'b0;
         vertex_a_ff   <= '0;
         vertex_b_ff   <= '0;
         vertex_c_ff   <= '0;
         radius_ff     <= '0;
         fill_color_ff <= '0;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_SHAPE_KIND: shape_kind_ff <= csr_wdata[0];
            CSR_VERTEX_A:   vertex_a_ff   <= csr_wdata[2*COORD_BITS-1:0];
            CSR_VERTEX_B:   vertex_b_ff   <= csr_wdata[2*COORD_BITS-1:0];
            CSR_VERTEX_C:   vertex_c_ff   <= csr_wdata[2*COORD_BITS-1:0];
            CSR_RADIUS:     radius_ff     <= csr_wdata[COORD_BITS-1:0];
            CSR_FILL_COLOR: fill_color_ff <= csr_wdata[COLOR_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign shape_kind = shape_kind_ff;
   assign vertex_a   = vertex_a_ff;
   assign vertex_b   = vertex_b_ff;
   assign vertex_c   = vertex_c_ff;
   assign radius     = radius_ff;
   assign fill_color = fill_color_ff;

endmodule

FILE: src/spct_cover_pipe.sv
// ----------------------------------------------------------------------------
// Shape pixel coverage test pipeline
// Four register stages: pixel capture, box test and edge operands, products,
// coverage decision. Each stage advances when it is empty or its successor moves.
// ----------------------------------------------------------------------------
module spct_cover_pipe #(
   parameter int COORD_BITS = spct_pkg::COORD_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   spct_req_if.sink                        req,
   spct_rsp_if.source                      rsp,
   input  logic                            shape_kind,
   input  logic [2*COORD_BITS-1:0]         vertex_a,
   input  logic [2*COORD_BITS-1:0]         vertex_b,
   input  logic [2*COORD_BITS-1:0]         vertex_c,
   input  logic [COORD_BITS-1:0]           radius,
   input  logic [spct_pkg::COLOR_BITS-1:0] fill_color
);
   import spct_pkg::*;

   localparam int C  = COORD_BITS;
   localparam int DW = C + 1;   // signed coordinate difference
   localparam int PW = 2 * DW;  // product
   localparam int SW = PW + 1;  // difference of two products
   localparam int TW = PW + 2;  // sum of edge values s and t
   localparam int NP = 6;       // products per pixel

   function automatic logic signed [DW-1:0] sdiff(input logic [C-1:0] a,
                                                 input logic [C-1:0] b);
      sdiff = $signed({1'b0, a}) - $signed({1'b0, b});
   endfunction

   // ---------------- handshake chain ----------------
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic rdy1, rdy2, rdy3, rdy4;

   assign rdy4 = !v4_ff || rsp.ready;
   assign rdy3 = !v3_ff || rdy4;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;
   assign req.ready = rdy1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req.valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
      end
   end

   // ---------------- stage 1: pixel capture ----------------
   logic [C-1:0] x1_ff, y1_ff;

   always_ff @(posedge clock) begin
      if (rdy1 && req.valid) begin
         x1_ff <= req.pixel_x;
         y1_ff <= req.pixel_y;
      end
   end

   // ---------------- stage 2: box test and operands ----------------
   logic [C-1:0] ax, ay, bx, by, cx, cy;
   logic [C-1:0] min_x, max_x, min_y, max_y;
   logic [C:0]   xe, ye, re, axe, aye;
   logic         tri_box, circ_box;
   logic         box2_in, box2_ff, kind2_ff;
   logic [C-1:0] x2_ff, y2_ff;
   logic signed [DW-1:0] fa_in [NP];
   logic signed [DW-1:0] fb_in [NP];
   logic signed [DW-1:0] fa_ff [NP];
   logic signed [DW-1:0] fb_ff [NP];

   assign ax = vertex_a[C-1:0];
   assign ay = vertex_a[2*C-1:C];
   assign bx = vertex_b[C-1:0];
   assign by = vertex_b[2*C-1:C];
   assign cx = vertex_c[C-1:0];
   assign cy = vertex_c[2*C-1:C];

   always_comb begin
      min_x = (ax < bx) ? ax : bx;
      min_x = (min_x < cx) ? min_x : cx;
      max_x = (ax > bx) ? ax : bx;
      max_x = (max_x > cx) ? max_x : cx;
      min_y = (ay < by) ? ay : by;
      min_y = (min_y < cy) ? min_y : cy;
      max_y = (ay > by) ? ay : by;
      max_y = (max_y > cy) ? max_y : cy;
   end

   assign tri_box = (x1_ff >= min_x) && (x1_ff < max_x) &&
                    (y1_ff >= min_y) && (y1_ff < max_y);

   // The circle's lower corner clamps at zero; testing x + r >= ax instead of
   // x >= ax - r gives the clamped result, since x is never negative.
   assign xe  = {1'b0, x1_ff};
   assign ye  = {1'b0, y1_ff};
   assign re  = {1'b0, radius};
   assign axe = {1'b0, ax};
   assign aye = {1'b0, ay};
   assign circ_box = (xe + re >= axe) && (xe < axe + re) &&
                     (ye + re >= aye) && (ye < aye + re);

   assign box2_in = (shape_kind == SHAPE_CIRCLE) ? circ_box : tri_box;

   always_comb begin
      case (shape_kind)
         SHAPE_CIRCLE: begin
            fa_in[0] = sdiff(ax, x1_ff);
            fb_in[0] = sdiff(ax, x1_ff);
            fa_in[1] = sdiff(ay, y1_ff);
            fb_in[1] = sdiff(ay, y1_ff);
            fa_in[2] = $signed(re);
            fb_in[2] = $signed(re);
            fa_in[3] = '0;
            fb_in[3] = '0;
            fa_in[4] = '0;
            fb_in[4] = '0;
            fa_in[5] = '0;
            fb_in[5] = '0;
         end
         default: begin
            fa_in[0] = sdiff(ax, cx);
            fb_in[0] = sdiff(y1_ff, cy);
            fa_in[1] = sdiff(ay, cy);
            fb_in[1] = sdiff(x1_ff, cx);
            fa_in[2] = sdiff(bx, ax);
            fb_in[2] = sdiff(y1_ff, ay);
            fa_in[3] = sdiff(by, ay);
            fb_in[3] = sdiff(x1_ff, ax);
            fa_in[4] = sdiff(cx, bx);
            fb_in[4] = sdiff(y1_ff, by);
            fa_in[5] = sdiff(cy, by);
            fb_in[5] = sdiff(x1_ff, bx);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (rdy2 && v1_ff) begin
         box2_ff  <= box2_in;
         kind2_ff <= shape_kind;
         x2_ff    <= x1_ff;
         y2_ff    <= y1_ff;
         for (int i = 0; i < NP; i++) begin
            fa_ff[i] <= fa_in[i];
            fb_ff[i] <= fb_in[i];
         end
      end
   end

   // ---------------- stage 3: products ----------------
   logic signed [PW-1:0] prod_ff [NP];
   logic                 box3_ff, kind3_ff;
   logic [C-1:0]         x3_ff, y3_ff;

   always_ff @(posedge clock) begin
      if (rdy3 && v2_ff) begin
         box3_ff  <= box2_ff;
         kind3_ff <= kind2_ff;
         x3_ff    <= x2_ff;
         y3_ff    <= y2_ff;
         for (int i = 0; i < NP; i++) begin
            prod_ff[i] <= PW'(fa_ff[i]) * PW'(fb_ff[i]);
         end
      end
   end

   // ---------------- stage 4: coverage decision ----------------
   logic signed [SW-1:0] s_val, t_val, d_val, dist_sq;
   logic signed [TW-1:0] st_val;
   logic                 tri_ok, circ_ok, write_in;
   logic                 write_ff;
   logic [C-1:0]         x4_ff, y4_ff;

   assign s_val   = SW'(prod_ff[0]) - SW'(prod_ff[1]);
   assign t_val   = SW'(prod_ff[2]) - SW'(prod_ff[3]);
   assign d_val   = SW'(prod_ff[4]) - SW'(prod_ff[5]);
   assign st_val  = TW'(s_val) + TW'(t_val);
   assign dist_sq = SW'(prod_ff[0]) + SW'(prod_ff[1]);

   // Opposite nonzero signs of s and t reject; otherwise d decides unless zero.
   assign tri_ok = !((s_val[SW-1] != t_val[SW-1]) && (s_val != '0) && (t_val != '0)) &&
                   ((d_val == '0) ||
                    (d_val[SW-1] == (st_val[TW-1] || (st_val == '0))));
   assign circ_ok = dist_sq < SW'(prod_ff[2]);

   assign write_in = box3_ff && ((kind3_ff == SHAPE_CIRCLE) ? circ_ok : tri_ok);

   always_ff @(posedge clock) begin
      if (rdy4 && v3_ff) begin
         write_ff <= write_in;
         x4_ff    <= x3_ff;
         y4_ff    <= y3_ff;
      end
   end

   assign rsp.valid       = v4_ff;
   assign rsp.write_pixel = write_ff;
   assign rsp.out_x       = x4_ff;
   assign rsp.out_y       = y4_ff;
   assign rsp.red         = fill_color[3*CHANNEL_BITS-1:2*CHANNEL_BITS];
   assign rsp.green       = fill_color[2*CHANNEL_BITS-1:CHANNEL_BITS];
   assign rsp.blue        = fill_color[CHANNEL_BITS-1:0];

`ifndef ASSERT_OFF
   a_accept_fills_stage1: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> v1_ff)
      else $error("accepted transaction did not reach the input stage");

   a_outside_box_not_written: assert property (@(posedge clock) disable iff (reset)
      (rdy4 && v3_ff && !box3_ff) |=> !write_ff)
      else $error("pixel outside the bounding box was written");

   a_zero_radius_covers_nothing: assert property (@(posedge clock) disable iff (reset)
      (rdy4 && v3_ff && (kind3_ff == SHAPE_CIRCLE) && (prod_ff[2] == '0)) |=> !write_ff)
      else $error("circle with zero radius covered a pixel");

   a_circle_squares_nonnegative: assert property (@(posedge clock) disable iff (reset)
      (v3_ff && (kind3_ff == SHAPE_CIRCLE)) |-> (!prod_ff[0][PW-1] && !prod_ff[1][PW-1]))
      else $error("negative squared distance term");
`endif

endmodule

FILE: src/shape_pixel_coverage_test_core.sv
// ----------------------------------------------------------------------------
// Shape pixel coverage test core
// Decides whether a pixel is covered by a configured triangle or circle.
// ----------------------------------------------------------------------------
//  channel   direction  payload
//  req_chan  in         pixel_x, pixel_y
//  rsp_chan  out        write_pixel, out_x, out_y, red, green, blue
//  csr_*     in         csr_wen, csr_index, csr_wdata (write only)
//
// One transaction per cycle is accepted unless all stages are full and the response
// waits; a request passes the input, operand, product and result registers in turn.
// Each register stage advances when empty or when its successor moves, so
// requests keep entering while a stalled response waits, until the stages fill.
// Synchronous reset clears the stage valid bits and all configuration registers.
// ----------------------------------------------------------------------------
module shape_pixel_coverage_test_core #(
   parameter int COORD_BITS = spct_pkg::COORD_BITS_DEF,
   localparam int CSR_DATA_BITS = (2 * COORD_BITS > spct_pkg::COLOR_BITS) ?
                                  2 * COORD_BITS : spct_pkg::COLOR_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   spct_req_if.sink                            req_chan,
   spct_rsp_if.source                          rsp_chan,
   input  logic                                csr_wen,
   input  logic [spct_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]            csr_wdata
);
   import spct_pkg::*;

   logic                    shape_kind;
   logic [2*COORD_BITS-1:0] vertex_a;
   logic [2*COORD_BITS-1:0] vertex_b;
   logic [2*COORD_BITS-1:0] vertex_c;
   logic [COORD_BITS-1:0]   radius;
   logic [COLOR_BITS-1:0]   fill_color;

   spct_cfg_regs #(
      .COORD_BITS    (COORD_BITS),
      .CSR_DATA_BITS (CSR_DATA_BITS)
   ) u_cfg_regs (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .shape_kind (shape_kind),
      .vertex_a   (vertex_a),
      .vertex_b   (vertex_b),
      .vertex_c   (vertex_c),
      .radius     (radius),
      .fill_color (fill_color)
   );

   spct_cover_pipe #(
      .COORD_BITS (COORD_BITS)
   ) u_cover_pipe (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .rsp        (rsp_chan),
      .shape_kind (shape_kind),
      .vertex_a   (vertex_a),
      .vertex_b   (vertex_b),
      .vertex_c   (vertex_c),
      .radius     (radius),
      .fill_color (fill_color)
   );

endmodule
